### design/emgenv_pkg.sv
// ----------------------------------------------------------------------------
// emgenv_pkg
// Shared widths, codes and reset constants of the EMG envelope detector.
// ----------------------------------------------------------------------------
package emgenv_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int ALPHA_W     = 16;
  localparam int SAT_W       = 12;
  localparam int BASE_W      = 16;
  localparam int ENV_W       = 20;
  localparam int SUM_W       = 28;
  localparam int REQ_W       = 2;
  localparam int FRAC_SH     = 4;                      // Q12.4 <-> integer, Q12.4 -> Q12.8
  localparam int DIFF_W      = ENV_W + 1;              // signed rect - envelope
  localparam int ACC_W       = DIFF_W + 1;             // multiplier high word
  localparam int NUM_W       = SUM_W + FRAC_SH + 1;    // sum*16 + count/2
  localparam int QUO_W       = BASE_W;
  localparam int HI_W        = NUM_W - QUO_W;
  localparam int STEP_CNT_W  = 4;                      // 16 serial steps
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = SAMPLE_W + BASE_W + ENV_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [ALPHA_W-1:0] RST_ALPHA     = 16'd6554;
  localparam logic [SAT_W-1:0]   RST_SAT_LEVEL = 12'd4000;
  localparam logic [SAMPLE_W-1:0] RST_DEF_BASE = 12'd2048;
  localparam logic [ENV_W-1:0]   ENV_MAX       = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX       = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_MEASURE = 2'd0,
    REQ_CALIB   = 2'd1,
    REQ_DEFAULT = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA     = 2'd0,
    CFG_SAT_LEVEL = 2'd1,
    CFG_DEF_BASE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### design/emgenv_mul.sv
// ----------------------------------------------------------------------------
// emgenv_mul
// Bit-serial signed multiply of alpha (Q0.16) by a signed difference, with
// round-half-up of the product to integer (>> 16). One alpha bit per cycle.
// ----------------------------------------------------------------------------
module emgenv_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [emgenv_pkg::ALPHA_W-1:0]      alpha_i,
  input  logic signed [emgenv_pkg::DIFF_W-1:0] diff_i,
  output emgenv_pkg::unit_stat_t              stat_o,
  output logic [emgenv_pkg::ACC_W-1:0]        prod_o
);
  import emgenv_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic [ALPHA_W-1:0]    alpha_sr_q, alpha_sr_d;
  logic [DIFF_W-1:0]     diff_q, diff_d;
  logic [ACC_W-1:0]      hi_q, hi_d;
  logic                  rnd_q, rnd_d;
  logic [ACC_W-1:0]      addend;
  logic [ACC_W-1:0]      sum;

  // shift-add, high word moves right; the last bit shifted out is product bit 15
  assign addend = alpha_sr_q[0] ? {diff_q[DIFF_W-1], diff_q} : '0;
  assign sum    = hi_q + addend;

  always_comb begin
    busy_d     = busy_q;
    done_d     = 1'b0;
    cnt_d      = cnt_q;
    alpha_sr_d = alpha_sr_q;
    diff_d     = diff_q;
    hi_d       = hi_q;
    rnd_d      = rnd_q;
    if (start_i) begin
      busy_d     = 1'b1;
      cnt_d      = '0;
      alpha_sr_d = alpha_i;
      diff_d     = diff_i;
      hi_d       = '0;
      rnd_d      = 1'b0;
    end else if (busy_q) begin
      alpha_sr_d = {1'b0, alpha_sr_q[ALPHA_W-1:1]};
      hi_d       = {sum[ACC_W-1], sum[ACC_W-1:1]};
      rnd_d      = sum[0];
      cnt_d      = cnt_q + 1'b1;
      if (cnt_q == STEP_CNT_W'(ALPHA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_sr_q <= alpha_sr_d;
    diff_q     <= diff_d;
    hi_q       <= hi_d;
    rnd_q      <= rnd_d;
  end

  assign prod_o      = hi_q + ACC_W'(rnd_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### design/emgenv_div.sv
// ----------------------------------------------------------------------------
// emgenv_div
// Restoring divider for the calibration mean: (sum*16 + count/2) / count,
// saturated to 16 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module emgenv_div #(
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [emgenv_pkg::SUM_W-1:0]    sum_i,
  input  logic [COUNT_BITS-1:0]           count_i,
  output emgenv_pkg::unit_stat_t          stat_o,
  output logic [emgenv_pkg::QUO_W-1:0]    quo_o
);
  import emgenv_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] den_q, den_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]      low_sr_q, low_sr_d;
  logic [QUO_W-1:0]      quo_q, quo_d;
  logic [NUM_W-1:0]      num;
  logic [HI_W-1:0]       num_hi;
  logic                  ovf;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   trial_sub;
  logic                  ge;

  assign num    = NUM_W'({sum_i, {FRAC_SH{1'b0}}}) + NUM_W'(count_i >> 1);
  assign num_hi = num[NUM_W-1:QUO_W];
  // quotient overflows 16 bits exactly when the upper part already reaches count
  assign ovf    = num_hi >= HI_W'(count_i);

  assign trial     = {rem_q, low_sr_q[QUO_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = trial >= {1'b0, den_q};

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    den_d    = den_q;
    rem_d    = rem_q;
    low_sr_d = low_sr_q;
    quo_d    = quo_q;
    if (start_i) begin
      den_d    = count_i;
      rem_d    = num_hi[COUNT_BITS-1:0];
      low_sr_d = num[QUO_W-1:0];
      cnt_d    = '0;
      if (ovf) begin
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        quo_d  = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d    = ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      low_sr_d = {low_sr_q[QUO_W-2:0], 1'b0};
      quo_d    = {quo_q[QUO_W-2:0], ge};
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == STEP_CNT_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q    <= den_d;
    rem_q    <= rem_d;
    low_sr_q <= low_sr_d;
    quo_q    <= quo_d;
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### design/emg_envelope_with_baseline_cal.sv
// ----------------------------------------------------------------------------
// emg_envelope_with_baseline_cal
// Rectified EMA envelope detector with baseline calibration.
//
//   Channel   Dir  Transfer when            Carries
//   s_axis    in   tvalid & tready          sample (tdata), req_type (tuser),
//                                           calib_last (tlast)
//   m_axis    out  tvalid & tready          raw_echo, baseline_out, envelope
//                                           (tdata), saturated (tuser)
//   cfg       in   cfg_valid_i & cfg_ready_o register index and write data
//
// One item at a time: a new item is taken only after the last result has been
// loaded into the output register. A measure item runs through the 16-step
// bit-serial alpha multiplier; a last calibration item runs through the 16-step
// serial divider unless the quotient saturates. Other items go straight to output.
// A held result in the output register blocks only the loading of the next one.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module emg_envelope_with_baseline_cal #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // [11:0] sample, rest zero
  input  logic [emgenv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] req_type
  input  logic [emgenv_pkg::REQ_W-1:0]         s_axis_tuser,
  input  logic                                 s_axis_tlast,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [11:0] raw_echo, [27:12] baseline_out, [47:28] envelope
  output logic [emgenv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] saturated
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [emgenv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [emgenv_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import emgenv_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_INIT = 3'd1;
  localparam logic [2:0] ST_MUL      = 3'd2;
  localparam logic [2:0] ST_DIV_INIT = 3'd3;
  localparam logic [2:0] ST_DIV      = 3'd4;
  localparam logic [2:0] ST_OUT      = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [ALPHA_W-1:0]    alpha_q, alpha_d;
  logic [SAT_W-1:0]      sat_level_q, sat_level_d;
  logic [SAMPLE_W-1:0]   def_base_q, def_base_d;
  logic [ENV_W-1:0]      env_q, env_d;
  logic [BASE_W-1:0]     base_q, base_d;
  logic                  sat_flag_q, sat_flag_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]   sample_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                  out_sat_q;

  logic                  in_fire;
  logic                  out_load;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [SUM_W:0]        sum_ext;
  logic [BASE_W-1:0]     s4;
  logic [BASE_W-1:0]     rect;
  logic [ENV_W-1:0]      r8;
  logic [DIFF_W-1:0]     diff;
  logic                  mul_start;
  logic                  div_start;
  unit_stat_t            mul_stat;
  unit_stat_t            div_stat;
  logic [ACC_W-1:0]      prod;
  logic [ACC_W-1:0]      env_new;
  logic [QUO_W-1:0]      quo;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_sample     = s_axis_tdata[SAMPLE_W-1:0];
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(in_sample);

  // rectify in Q12.4, then step to Q12.8 and take the signed distance to env
  assign s4   = {sample_q, {FRAC_SH{1'b0}}};
  assign rect = (s4 >= base_q) ? (s4 - base_q) : (base_q - s4);
  assign r8   = {rect, {FRAC_SH{1'b0}}};
  assign diff = {1'b0, r8} - {1'b0, env_q};

  assign mul_start = (state_q == ST_MUL_INIT);
  assign div_start = (state_q == ST_DIV_INIT);
  assign env_new   = ACC_W'(env_q) + prod;

  emgenv_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .alpha_i (alpha_q),
    .diff_i  (diff),
    .stat_o  (mul_stat),
    .prod_o  (prod)
  );

  emgenv_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_q),
    .count_i (count_q),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  always_comb begin
    alpha_d     = alpha_q;
    sat_level_d = sat_level_q;
    def_base_d  = def_base_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ALPHA:     alpha_d     = cfg_data_i[ALPHA_W-1:0];
        CFG_SAT_LEVEL: sat_level_d = cfg_data_i[SAT_W-1:0];
        CFG_DEF_BASE:  def_base_d  = cfg_data_i[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    env_d       = env_q;
    base_d      = base_q;
    sat_flag_d  = sat_flag_q;
    sum_d       = sum_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_OUT;
          unique case (req_e'(s_axis_tuser))
            REQ_MEASURE: begin
              sat_flag_d = (in_sample >= sat_level_q);
              state_d    = ST_MUL_INIT;
            end
            REQ_CALIB: begin
              // a full count ignores the sample but still honors the last mark
              if (count_q != COUNT_MAX) begin
                sum_d   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                count_d = count_q + 1'b1;
              end
              if (s_axis_tlast) begin
                state_d = ST_DIV_INIT;
              end
            end
            REQ_DEFAULT: begin
              base_d  = {def_base_q, {FRAC_SH{1'b0}}};
              env_d   = '0;
              sum_d   = '0;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MUL_INIT: state_d = ST_MUL;
      ST_MUL: begin
        if (mul_stat.done) begin
          if (env_new[ACC_W-1]) begin
            env_d = '0;
          end else if (env_new[ACC_W-2:ENV_W] != '0) begin
            env_d = ENV_MAX;
          end else begin
            env_d = env_new[ENV_W-1:0];
          end
          state_d = ST_OUT;
        end
      end
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          base_d  = quo;
          env_d   = '0;
          sum_d   = '0;
          count_d = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      alpha_q     <= RST_ALPHA;
      sat_level_q <= RST_SAT_LEVEL;
      def_base_q  <= RST_DEF_BASE;
      env_q       <= '0;
      base_q      <= {RST_DEF_BASE, {FRAC_SH{1'b0}}};
      sat_flag_q  <= 1'b0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      alpha_q     <= alpha_d;
      sat_level_q <= sat_level_d;
      def_base_q  <= def_base_d;
      env_q       <= env_d;
      base_q      <= base_d;
      sat_flag_q  <= sat_flag_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_sample;
    end
    if (out_load) begin
      out_data_q <= {env_q, base_q, sample_q};
      out_sat_q  <= sat_flag_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

endmodule

### design/emgenv_checker.sv
// ----------------------------------------------------------------------------
// emgenv_checker
// Port-level checks of the envelope detector, bound to the top level.
// ----------------------------------------------------------------------------
module emgenv_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic [emgenv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input logic [emgenv_pkg::REQ_W-1:0]         s_axis_tuser,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [emgenv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                                 m_axis_tuser,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready
);
  import emgenv_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // a default item taken with a free output shows up after the output state, envelope cleared
  a_default_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (s_axis_tuser == REQ_DEFAULT) && !m_axis_tvalid |=> ##1
      m_axis_tvalid && (m_axis_tdata[OUT_TDATA_W-1:SAMPLE_W+BASE_W] == '0) &&
      (m_axis_tdata[SAMPLE_W-1:0] == $past(s_axis_tdata[SAMPLE_W-1:0], 2)))
    else $error("default item result wrong");

endmodule

bind emg_envelope_with_baseline_cal emgenv_checker u_emgenv_checker (.*);
